// File: hw/rtl/redmean_color_distance_top_assert.svh
// ----------------------------------------------------------------------------
// Redmean color distance assertion macros
// Shared property forms for the color distance pipeline checks.
// ----------------------------------------------------------------------------
`ifndef REDMEAN_COLOR_DISTANCE_TOP_ASSERT_SVH
`define REDMEAN_COLOR_DISTANCE_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define RCD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rcd assertion failed");

// next-cycle implication, checked out of reset
`define RCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rcd assertion failed");

`endif

// File: hw/rtl/rcd_pkg.sv
// ----------------------------------------------------------------------------
// Redmean color distance package
// Word types and fixed constants of the color distance pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rcd_pkg;

  typedef struct packed {
    logic [7:0] first_red;
    logic [7:0] first_green;
    logic [7:0] first_blue;
    logic       first_is_clear;
    logic [7:0] second_red;
    logic [7:0] second_green;
    logic [7:0] second_blue;
    logic       second_is_clear;
  } rcd_in_t;

  typedef struct packed {
    logic [28:0] weighted_square_sum;
    logic [16:0] normalized_distance;
  } rcd_out_t;

  // pipeline depth, output register included
  localparam int STAGES = 17;

  localparam logic [10:0] RED_BASE  = 11'd1024;
  localparam logic [10:0] BLUE_BASE = 11'd1534;

  // distance = floor(root * 256000 / 764833), root has 8 fraction bits
  localparam logic [17:0] SCALE_NUM = 18'd256000;
  localparam logic [19:0] DIV_D     = 20'd764833;
  // floor(2^20 * 256000 / 764833)
  localparam logic [18:0] RECIP_M   = 19'd350972;
  localparam int          RECIP_SH  = 20;

  localparam logic [16:0] Q16_ONE = 17'd65536;

endpackage

// File: hw/rtl/redmean_color_distance_top.sv
// Redmean color distance pipeline.
// Depth: 17 register stages, passed in order from stage 1 to the output register.
// Throughput: one word per cycle while out_stall is low; the ready chain is
// combinational, so a stage refills as soon as its word moves on and out_stall
// reaches in_stall at once.
// Reset clears only the stage valid bits.
// ----------------------------------------------------------------------------
// Redmean color distance top level
// Weighted square sum, 18-bit root over nine stages, and scaled distance.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "redmean_color_distance_top_assert.svh"

module redmean_color_distance_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  rcd_pkg::rcd_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output rcd_pkg::rcd_out_t out_data
);
  import rcd_pkg::*;

  typedef struct packed {
    logic [19:0] rem;
    logic [17:0] root;
  } sq_step_t;

  // one restoring square root digit
  function automatic sq_step_t sq_step(input sq_step_t cur, input logic [1:0] bits);
    logic [21:0] sh;
    logic [21:0] trial;
    sq_step_t    res;
    sh    = {cur.rem, bits};
    trial = {2'b00, cur.root, 2'b01};
    if (sh >= trial) begin
      res.rem  = 20'(sh - trial);
      res.root = {cur.root[16:0], 1'b1};
    end else begin
      res.rem  = sh[19:0];
      res.root = {cur.root[16:0], 1'b0};
    end
    return res;
  endfunction

  logic [STAGES:1]   vld_r;
  logic [STAGES+1:1] rdy;

  assign rdy[STAGES+1] = !out_stall;

  genvar g;
  generate
    for (g = 1; g <= STAGES; g++) begin : g_ctl
      assign rdy[g] = !vld_r[g] || rdy[g+1];
      if (g == 1) begin : g_first
        always_ff @(posedge clk) begin
          if (!rst_n) begin
            vld_r[g] <= 1'b0;
          end else if (rdy[g]) begin
            vld_r[g] <= in_valid;
          end
        end
      end else begin : g_rest
        always_ff @(posedge clk) begin
          if (!rst_n) begin
            vld_r[g] <= 1'b0;
          end else if (rdy[g]) begin
            vld_r[g] <= vld_r[g-1];
          end
        end
      end
    end
  endgenerate

  assign in_stall  = !rdy[1];
  assign out_valid = vld_r[STAGES];

  // stage 1: channel differences and red and blue weights
  logic        clr;
  logic [8:0]  rsum;
  logic [7:0]  s1_dr_r, s1_dg_r, s1_db_r;
  logic [10:0] s1_wr_r, s1_wb_r;

  assign clr  = in_data.first_is_clear || in_data.second_is_clear;
  assign rsum = {1'b0, in_data.first_red} + {1'b0, in_data.second_red};

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      // a clear color zeroes every difference, so the sum and distance are zero
      if (clr) begin
        s1_dr_r <= '0;
        s1_dg_r <= '0;
        s1_db_r <= '0;
      end else begin
        s1_dr_r <= (in_data.first_red > in_data.second_red) ?
                   in_data.first_red - in_data.second_red :
                   in_data.second_red - in_data.first_red;
        s1_dg_r <= (in_data.first_green > in_data.second_green) ?
                   in_data.first_green - in_data.second_green :
                   in_data.second_green - in_data.first_green;
        s1_db_r <= (in_data.first_blue > in_data.second_blue) ?
                   in_data.first_blue - in_data.second_blue :
                   in_data.second_blue - in_data.first_blue;
      end
      s1_wr_r <= RED_BASE + {2'b00, rsum};
      s1_wb_r <= BLUE_BASE - {2'b00, rsum};
    end
  end

  // stage 2: squares
  logic [15:0] s2_sr_r, s2_sg_r, s2_sb_r;
  logic [10:0] s2_wr_r, s2_wb_r;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s2_sr_r <= {8'd0, s1_dr_r} * {8'd0, s1_dr_r};
      s2_sg_r <= {8'd0, s1_dg_r} * {8'd0, s1_dg_r};
      s2_sb_r <= {8'd0, s1_db_r} * {8'd0, s1_db_r};
      s2_wr_r <= s1_wr_r;
      s2_wb_r <= s1_wb_r;
    end
  end

  // stage 3: weighted terms
  logic [26:0] s3_pr_r, s3_pg_r, s3_pb_r;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s3_pr_r <= {16'd0, s2_wr_r} * {11'd0, s2_sr_r};
      s3_pg_r <= {s2_sg_r, 11'd0};
      s3_pb_r <= {16'd0, s2_wb_r} * {11'd0, s2_sb_r};
    end
  end

  // stage 4: weighted square sum
  logic [28:0] s4_sum_r;

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      s4_sum_r <= {2'b00, s3_pr_r} + {2'b00, s3_pg_r} + {2'b00, s3_pb_r};
    end
  end

  // stages 5..13: root of 128 * sum, two digits per stage
  sq_step_t    sq_r [0:8];
  logic [28:0] sq_s_r [0:8];

  generate
    for (g = 0; g < 9; g++) begin : g_sqrt
      sq_step_t    cur;
      sq_step_t    mid;
      sq_step_t    nxt;
      logic [28:0] s_in;
      logic [35:0] rad;

      if (g == 0) begin : g_head
        assign cur  = '0;
        assign s_in = s4_sum_r;
      end else begin : g_body
        assign cur  = sq_r[g-1];
        assign s_in = sq_s_r[g-1];
      end

      assign rad = {s_in, 7'd0};
      assign mid = sq_step(cur, rad[35-4*g -: 2]);
      assign nxt = sq_step(mid, rad[33-4*g -: 2]);

      always_ff @(posedge clk) begin
        if (rdy[5+g]) begin
          sq_r[g]   <= nxt;
          sq_s_r[g] <= s_in;
        end
      end
    end
  endgenerate

  // stage 14: reciprocal estimate and exact numerator
  logic [36:0] s14_p_r;
  logic [35:0] s14_n_r;
  logic [28:0] s14_s_r;

  always_ff @(posedge clk) begin
    if (rdy[14]) begin
      s14_p_r <= {19'd0, sq_r[8].root} * {18'd0, RECIP_M};
      s14_n_r <= {18'd0, sq_r[8].root} * {18'd0, SCALE_NUM};
      s14_s_r <= sq_s_r[8];
    end
  end

  // stage 15: back-multiply the quotient estimate, which is low by at most one
  logic [16:0] q_est;
  logic [16:0] s15_q_r;
  logic [36:0] s15_t_r;
  logic [35:0] s15_n_r;
  logic [28:0] s15_s_r;

  assign q_est = s14_p_r[RECIP_SH +: 17];

  always_ff @(posedge clk) begin
    if (rdy[15]) begin
      s15_q_r <= q_est;
      s15_t_r <= {20'd0, q_est} * {17'd0, DIV_D};
      s15_n_r <= s14_n_r;
      s15_s_r <= s14_s_r;
    end
  end

  // stage 16: remainder check corrects the estimate
  logic [36:0] rmd;
  logic [16:0] s16_q_r;
  logic [28:0] s16_s_r;

  assign rmd = {1'b0, s15_n_r} - s15_t_r;

  always_ff @(posedge clk) begin
    if (rdy[16]) begin
      s16_q_r <= s15_q_r + {16'd0, (rmd >= {17'd0, DIV_D})};
      s16_s_r <= s15_s_r;
    end
  end

  // stage 17: saturate at 1.0 into the output register
  rcd_out_t out_r;

  always_ff @(posedge clk) begin
    if (rdy[17]) begin
      out_r.weighted_square_sum <= s16_s_r;
      out_r.normalized_distance <= (s16_q_r > Q16_ONE) ? Q16_ONE : s16_q_r;
    end
  end

  assign out_data = out_r;

  `RCD_ASSERT_IMPLY(a_dist_sat, clk, rst_n, out_valid, out_data.normalized_distance <= Q16_ONE)
  `RCD_ASSERT_IMPLY(a_zero_sum, clk, rst_n, out_valid && (out_data.weighted_square_sum == '0), out_data.normalized_distance == '0)
  `RCD_ASSERT_NEXT(a_clear_zero, clk, rst_n, in_valid && !in_stall && clr, (s1_dr_r == '0) && (s1_dg_r == '0) && (s1_db_r == '0))
  `RCD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))

endmodule

// File: verif/tb_redmean_color_distance_top.sv
// ----------------------------------------------------------------------------
// Redmean color distance testbench
// Streams pixel-pair words through the pipeline under random sender bursts
// and receiver stalls, and compares each result word with a local model of
// the weighted square sum and the Q1.16 normalized distance.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_redmean_color_distance_top;
  import rcd_pkg::*;

  localparam int RAND_FIRST  = 900;
  localparam int RAND_SECOND = 1000;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 10;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  rcd_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  rcd_out_t out_data;

  rcd_in_t  pair_q[$];
  rcd_out_t dist_q[$];
  int       err_cnt = 0;
  int       cycles = 0;

  // sender burst shaping
  int burst_left = 0;
  int gap_left = 0;
  // receiver stall shaping
  int stall_mode = 0;
  int stall_left = 0;
  int stall_phase = 0;

  redmean_color_distance_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #6 clk = ~clk;

  // floor square root, one result bit at a time
  function automatic longint unsigned floor_root(input longint unsigned v);
    longint unsigned acc;
    longint unsigned trial;
    acc = 0;
    for (int b = 19; b >= 0; b--) begin
      trial = acc | (64'd1 << b);
      if (trial * trial <= v) acc = trial;
    end
    return acc;
  endfunction

  function automatic rcd_out_t redmean_predict(input rcd_in_t w);
    longint unsigned dr, dg, db, rsum, wsum, root, nd;
    rcd_out_t r;
    r = '0;
    if (w.first_is_clear || w.second_is_clear) return r;
    dr = (w.first_red > w.second_red) ? w.first_red - w.second_red
                                      : w.second_red - w.first_red;
    dg = (w.first_green > w.second_green) ? w.first_green - w.second_green
                                          : w.second_green - w.first_green;
    db = (w.first_blue > w.second_blue) ? w.first_blue - w.second_blue
                                        : w.second_blue - w.first_blue;
    rsum = longint'(w.first_red) + longint'(w.second_red);
    wsum = (longint'(RED_BASE) + rsum) * dr * dr + 64'd2048 * dg * dg
         + (longint'(BLUE_BASE) - rsum) * db * db;
    // root carries 8 fraction bits of sqrt(wsum / 512)
    root = floor_root(wsum * 64'd128);
    nd = root * 64'd256000 / 64'd764833;
    if (nd > longint'(Q16_ONE)) nd = longint'(Q16_ONE);
    r.weighted_square_sum = wsum[28:0];
    r.normalized_distance = nd[16:0];
    return r;
  endfunction

  task automatic add_pair(input logic [7:0] r1, g1, b1, input logic c1,
                          input logic [7:0] r2, g2, b2, input logic c2);
    rcd_in_t w;
    w.first_red = r1;
    w.first_green = g1;
    w.first_blue = b1;
    w.first_is_clear = c1;
    w.second_red = r2;
    w.second_green = g2;
    w.second_blue = b2;
    w.second_is_clear = c2;
    pair_q.push_back(w);
  endtask

  function automatic logic [7:0] pick_channel();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 8'd0;
    if (sel == 1) return 8'd255;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic rcd_in_t gen_pixel_pair();
    rcd_in_t w;
    int kind;
    w = rcd_in_t'(50'({$urandom, $urandom}));
    kind = $urandom_range(0, 19);
    w.first_is_clear = 1'b0;
    w.second_is_clear = 1'b0;
    if (kind < 2) begin
      // clear color on one or both sides, random channels kept
      w.first_is_clear = 1'($urandom_range(0, 1));
      w.second_is_clear = ~w.first_is_clear | 1'($urandom_range(0, 1));
    end else if (kind < 6) begin
      // near colors, small deltas
      w.first_red = pick_channel();
      w.first_green = pick_channel();
      w.first_blue = pick_channel();
      w.second_red = w.first_red + 8'($urandom_range(0, 6)) - 8'd3;
      w.second_green = w.first_green + 8'($urandom_range(0, 6)) - 8'd3;
      w.second_blue = w.first_blue + 8'($urandom_range(0, 6)) - 8'd3;
    end else if (kind < 9) begin
      // far colors, likely around saturation
      w.first_red = 8'($urandom_range(0, 24));
      w.first_green = 8'($urandom_range(0, 24));
      w.first_blue = 8'($urandom_range(0, 24));
      w.second_red = 8'($urandom_range(200, 255));
      w.second_green = 8'($urandom_range(200, 255));
      w.second_blue = 8'($urandom_range(200, 255));
      if ($urandom_range(0, 1)) begin
        {w.first_red, w.second_red} = {w.second_red, w.first_red};
        {w.first_blue, w.second_blue} = {w.second_blue, w.first_blue};
      end
    end else if (kind < 12) begin
      w.first_red = pick_channel();
      w.first_green = pick_channel();
      w.first_blue = pick_channel();
      w.second_red = pick_channel();
      w.second_green = pick_channel();
      w.second_blue = pick_channel();
    end
    return w;
  endfunction

  task automatic wait_drained();
    while (pair_q.size() != 0 || in_valid || dist_q.size() != 0) @(negedge clk);
  endtask

  // sender: predicts at accept, then loads the next word in bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) dist_q.push_back(redmean_predict(in_data));
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pair_q.size() == 0) begin
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_data <= pair_q.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            // about a third of bursts run straight into the next one
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // receiver stall pattern, switching between modes over random stretches
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        stall_left <= $urandom_range(10, 120);
        stall_phase <= 0;
      end else begin
        stall_left <= stall_left - 1;
        stall_phase <= stall_phase + 1;
      end
      case (stall_mode)
        0: begin
          out_stall <= 1'b0;
        end
        1: begin
          out_stall <= ($urandom_range(0, 3) == 0);
        end
        2: begin
          out_stall <= ($urandom_range(0, 3) != 0);
        end
        default: begin
          // long stall then a short release
          out_stall <= (stall_phase % 12) < 9;
        end
      endcase
    end
  end

  // result checker
  always @(posedge clk) begin
    rcd_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (dist_q.size() == 0) begin
        if (err_cnt < MAX_REPORTS)
          $display("unexpected result word: sum %0d dist %0d",
                   out_data.weighted_square_sum, out_data.normalized_distance);
        err_cnt <= err_cnt + 1;
      end else begin
        want = dist_q.pop_front();
        if (out_data.weighted_square_sum !== want.weighted_square_sum ||
            out_data.normalized_distance !== want.normalized_distance) begin
          if (err_cnt < MAX_REPORTS)
            $display("result word differs: sum exp %0d got %0d, dist exp %0d got %0d",
                     want.weighted_square_sum, out_data.weighted_square_sum,
                     want.normalized_distance, out_data.normalized_distance);
          err_cnt <= err_cnt + 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("redmean_color_distance_top: mismatch");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    add_pair(8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0);
    add_pair(8'd255, 8'd255, 8'd255, 1'b0, 8'd255, 8'd255, 8'd255, 1'b0);
    add_pair(8'd0, 8'd0, 8'd0, 1'b0, 8'd255, 8'd255, 8'd255, 1'b0);
    add_pair(8'd255, 8'd255, 8'd255, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0);
    // largest sum: full deltas with red sum of 255
    add_pair(8'd255, 8'd0, 8'd255, 1'b0, 8'd0, 8'd255, 8'd0, 1'b0);
    add_pair(8'd0, 8'd255, 8'd0, 1'b0, 8'd255, 8'd0, 8'd255, 1'b0);
    // single channel full swings, then one-step and zero deltas
    add_pair(8'd255, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0);
    add_pair(8'd0, 8'd255, 8'd0, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0);
    add_pair(8'd0, 8'd0, 8'd255, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0);
    add_pair(8'd255, 8'd0, 8'd0, 1'b0, 8'd255, 8'd0, 8'd255, 1'b0);
    add_pair(8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0, 8'd1, 1'b0);
    add_pair(8'd128, 8'd64, 8'd32, 1'b0, 8'd127, 8'd65, 8'd33, 1'b0);
    add_pair(8'd17, 8'd200, 8'd99, 1'b0, 8'd17, 8'd200, 8'd99, 1'b0);
    // clear color on one or both sides, then two ordinary pairs
    add_pair(8'd255, 8'd255, 8'd255, 1'b1, 8'd0, 8'd0, 8'd0, 1'b0);
    add_pair(8'd255, 8'd255, 8'd255, 1'b0, 8'd0, 8'd0, 8'd0, 1'b1);
    add_pair(8'd255, 8'd255, 8'd255, 1'b1, 8'd0, 8'd0, 8'd0, 1'b1);
    add_pair(8'd0, 8'd0, 8'd0, 1'b1, 8'd0, 8'd0, 8'd0, 1'b1);
    add_pair(8'd90, 8'd10, 8'd250, 1'b0, 8'd10, 8'd240, 8'd5, 1'b0);
    add_pair(8'd200, 8'd30, 8'd60, 1'b0, 8'd40, 8'd220, 8'd190, 1'b0);
    wait_drained();

    for (int i = 0; i < RAND_FIRST; i++) pair_q.push_back(gen_pixel_pair());
    // the second batch is queued only after the pipeline has emptied
    wait_drained();

    for (int i = 0; i < RAND_SECOND; i++) pair_q.push_back(gen_pixel_pair());
    wait_drained();
    repeat (4 * STAGES) @(posedge clk);

    if (err_cnt == 0) begin
      $display("redmean_color_distance_top: match");
    end else begin
      $display("redmean_color_distance_top: mismatch");
    end
    $finish;
  end

endmodule
